// ----- hw/rtl/crc64nv_pkg.sv -----
// ----------------------------------------------------------------------------
// crc64nv_pkg
// shared types, constants and the matrix builder for the crc-64/nvme engine
// ----------------------------------------------------------------------------
package crc64nv_pkg;

	localparam int unsigned CRC_W = 64;
	localparam int unsigned DATA_BYTES = 8;
	localparam int unsigned COUNT_W = 4;

	// bytes folded per word at most; counts above this saturate
	localparam int unsigned BYTES_PER_ITEM = 8;
	localparam int unsigned BYTE_LIMIT =
		(BYTES_PER_ITEM < DATA_BYTES) ? BYTES_PER_ITEM : DATA_BYTES;

	// reflected polynomial
	localparam logic [CRC_W-1:0] CRC_POLY = 64'h9A6C9329AC4BC9B5;
	localparam logic [CRC_W-1:0] CRC_INIT = '1;

	typedef logic [CRC_W-1:0] crc_t;
	typedef logic [CRC_W-1:0][CRC_W-1:0] crc_mat_t;

	// one input word as held in the input register
	typedef struct packed {
		logic [63:0]        data_bytes;
		logic [COUNT_W-1:0] byte_count;
		logic               first;
		logic [63:0]        seed;
		logic               last;
	} crc_item_t;

	// row i of the result is the xor of the input bits selected by m[i];
	// used for constants only, evaluated at elaboration
	function automatic crc_mat_t advance_matrix(input int nbits);
		crc_mat_t m;
		crc_t     v;
		m = '0;
		for (int j = 0; j < CRC_W; j++) begin
			v = crc_t'(1) << j;
			for (int s = 0; s < nbits; s++) begin
				if (v[0]) begin
					v = (v >> 1) ^ CRC_POLY;
				end else begin
					v = v >> 1;
				end
			end
			for (int i = 0; i < CRC_W; i++) begin
				m[i][j] = v[i];
			end
		end
		return m;
	endfunction

endpackage

// ----- hw/rtl/crc64nv_fold.sv -----
// ----------------------------------------------------------------------------
// crc64nv_fold
// folds up to eight bytes into the running remainder in one xor network
// ----------------------------------------------------------------------------
module crc64nv_fold (
	input  crc64nv_pkg::crc_t      rem,
	input  crc64nv_pkg::crc_item_t item,
	output crc64nv_pkg::crc_t      rem_next
);
	import crc64nv_pkg::*;

	localparam int unsigned NCAND = DATA_BYTES + 1;

	logic [COUNT_W-1:0] count_eff;
	crc_t               rem_in;
	logic [63:0]        data_mask;
	crc_t               x;
	crc_t               cand [NCAND];

	always_comb begin
		if (item.byte_count > COUNT_W'(BYTE_LIMIT)) begin
			count_eff = COUNT_W'(BYTE_LIMIT);
		end else begin
			count_eff = item.byte_count;
		end
	end

	// seed load on the first word of a message
	assign rem_in = item.first ? ~item.seed : rem;

	always_comb begin
		for (int k = 0; k < DATA_BYTES; k++) begin
			data_mask[k*8 +: 8] = (COUNT_W'(k) < count_eff) ? 8'hff : 8'h00;
		end
	end

	// for n bytes the reflected crc is rem ^ data shifted through 8n steps
	assign x = rem_in ^ (item.data_bytes & data_mask);

	for (genvar n = 0; n < NCAND; n++) begin : g_cand
		localparam crc_mat_t MAT = advance_matrix(8 * n);
		always_comb begin
			for (int i = 0; i < CRC_W; i++) begin
				cand[n][i] = ^(x & MAT[i]);
			end
		end
	end

	always_comb begin
		rem_next = rem_in;
		for (int n = 0; n < NCAND; n++) begin
			if (count_eff == COUNT_W'(n)) begin
				rem_next = cand[n];
			end
		end
	end

endmodule

// ----- hw/rtl/crc64_nvme_eight_byte_engine_top.sv -----
// ----------------------------------------------------------------------------
// crc64_nvme_eight_byte_engine_top
// reflected crc-64/nvme engine, one to eight bytes per word
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                       | tuser | tlast
// s_*     | in  | data_bytes[63:0] byte_count[67:64]        | first | last
//         |     | seed[131:68], zero pad to 136              |       |
// m_*     | out | crc_value[63:0]                            | -     | final_res
//
// every word moves from acceptance through an input register, then the fold
// network into the result register.
// while results are taken a new word is accepted every cycle; the running
// remainder updates as a word enters the result register, setting the rate.
// reset sets the running remainder to all ones (same as seed zero) and
// empties both stages.
// when the result is not taken, the pipeline holds; the input register
// still takes one word while it is empty.
// ----------------------------------------------------------------------------
module crc64_nvme_eight_byte_engine_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,  // data_bytes, byte_count, seed, zero pad
	input  logic [0:0]   s_tuser,  // first
	input  logic         s_tlast,  // last
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,  // crc_value
	output logic         m_tlast   // final_res
);
	import crc64nv_pkg::*;

	crc_item_t item_s1;
	logic      valid_s1;
	crc_t      rem_q;
	crc_t      rem_next;
	crc_t      crc_s2;
	logic      last_s2;
	logic      valid_s2;
	logic      advance;

	// result stage can take a new word
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.data_bytes <= s_tdata[63:0];
			item_s1.byte_count <= s_tdata[67:64];
			item_s1.seed       <= s_tdata[131:68];
			item_s1.first      <= s_tuser[0];
			item_s1.last       <= s_tlast;
		end
	end

	crc64nv_fold u_fold (
		.rem      (rem_q),
		.item     (item_s1),
		.rem_next (rem_next)
	);

	// running remainder moves with the word entering the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= CRC_INIT;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				rem_q <= rem_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			crc_s2  <= ~rem_next;
			last_s2 <= item_s1.last;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = crc_s2;
	assign m_tlast  = last_s2;

`ifndef SYNTH
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> m_tvalid)
		else $error("word in input stage did not reach result stage");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input not ready while result stage empty");

	a_rem_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && advance) |=> $stable(rem_q))
		else $error("running remainder changed without a word");

	a_result_matches_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> (m_tdata == ~rem_q))
		else $error("result differs from running remainder");
`endif

endmodule

// ----- verif/crc64_nvme_eight_byte_engine_checker.sv -----
// ----------------------------------------------------------------------------
// crc64_nvme_eight_byte_engine_checker
// watches both stream channels, predicts each crc word and compares in order
// ----------------------------------------------------------------------------
module crc64_nvme_eight_byte_engine_checker
	import crc64nv_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [135:0] s_tdata,  // data_bytes, byte_count, seed, zero pad
	input  logic [0:0]   s_tuser,  // first
	input  logic         s_tlast,  // last
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [63:0]  m_tdata,  // crc_value
	input  logic         m_tlast,  // final_res
	output int           mismatches,
	output int           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		crc_t crc;
		logic final_res;
	} crc_word_t;

	crc_t      running_crc;
	crc_word_t expected_crcs[$];
	int        fails;

	// one byte through the reflected shift register, low bit first
	function automatic crc_t fold_one_byte(crc_t rem, logic [7:0] b);
		crc_t r;
		r = rem ^ crc_t'(b);
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
		if (fails < 10) begin
			$display("%0t: %s expected %h got %h", $realtime, what, exp_v, act_v);
		end
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [63:0]        data;
		logic [COUNT_W-1:0] cnt;
		crc_word_t          exp_w;
		if (!arst_n) begin
			running_crc = CRC_INIT;
			expected_crcs.delete();
			fails = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			// results first, so a word never meets an expectation queued at the same edge
			if (m_tvalid && m_tready) begin
				if (expected_crcs.size() == 0) begin
					report_mismatch("unexpected crc word", '0, m_tdata);
				end else begin
					exp_w = expected_crcs.pop_front();
					if (m_tdata !== exp_w.crc) begin
						report_mismatch("crc_value", exp_w.crc, m_tdata);
					end
					if (m_tlast !== exp_w.final_res) begin
						report_mismatch("final_res", 64'(exp_w.final_res), 64'(m_tlast));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				data = s_tdata[63:0];
				cnt = s_tdata[67:64];
				if (cnt > BYTE_LIMIT) begin
					cnt = COUNT_W'(BYTE_LIMIT);
				end
				if (s_tuser[0]) begin
					running_crc = ~s_tdata[131:68];
				end
				for (int k = 0; k < cnt; k++) begin
					running_crc = fold_one_byte(running_crc, data[8*k +: 8]);
				end
				exp_w.crc = ~running_crc;
				exp_w.final_res = s_tlast;
				expected_crcs.push_back(exp_w);
			end
			mismatches <= fails;
			pending <= expected_crcs.size();
		end
	end

endmodule

// ----- verif/crc64_nvme_eight_byte_engine_top_tb.sv -----
// ----------------------------------------------------------------------------
// crc64_nvme_eight_byte_engine_top_tb
// stimulus and verdict for the crc-64/nvme engine: directed corner words, then
// random messages with random idling on both channels; checking is done by
// the checker module next to the engine
// ----------------------------------------------------------------------------
module crc64_nvme_eight_byte_engine_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import crc64nv_pkg::*;

	localparam int WORD_TARGET = 1350;
	localparam int CYCLE_LIMIT = 400000;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;   // data_bytes, byte_count, seed, zero pad
	logic [0:0]   s_tuser;   // first
	logic         s_tlast;   // last
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;   // crc_value
	logic         m_tlast;   // final_res

	int   mismatches;
	int   pending;
	int   words_sent;
	int   cycle_cnt;
	logic calm;              // no idling on either side while set
	logic s_taken;           // word accepted at the last rising edge

	// 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	crc64_nvme_eight_byte_engine_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	crc64_nvme_eight_byte_engine_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// handshake sampled at the rising edge, read by the sender at the falling edge
	always @(posedge clk) begin
		s_taken <= s_tvalid && s_tready;
	end

	// receiver: stalls about 16 percent of the time outside the calm stretch
	initial m_tready = 1'b0;
	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 16);
	end

	// watchdog, covers the slowest legal run several times over
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("crc64_nvme_eight_byte_engine_top: mismatch");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	// with tvalid still high, so back-to-back words need no drop of tvalid
	task automatic send_word(input logic [63:0] data, input logic [COUNT_W-1:0] cnt,
			input logic first, input logic [63:0] seed, input logic last);
		int gap;
		// a gap of random length comes before about 9 words in a hundred
		if (!calm && $urandom_range(99) < 9) begin
			gap = $urandom_range(3, 1);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, seed, cnt, data};
		s_tuser <= first;
		s_tlast <= last;
		do begin
			@(negedge clk);
		end while (!s_taken);
		words_sent++;
	endtask

	// a message: mostly a seed load on the first word, full words, a tail of
	// one to eight bytes marked last; now and then a count outside 1..8 as noise
	task automatic send_message();
		int          nwords;
		int          sel;
		logic        seeded;
		logic [63:0] seed;
		logic [3:0]  cnt;
		nwords = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
		seeded = ($urandom_range(9) != 0);   // otherwise carry on from the last message
		sel = $urandom_range(9);
		seed = (sel < 5) ? 64'd0 : (sel == 5) ? '1 : rand64();
		for (int w = 0; w < nwords; w++) begin
			if ($urandom_range(99) < 8) begin
				cnt = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(15, 9));
			end else if (w == nwords - 1) begin
				cnt = 4'($urandom_range(8, 1));
			end else begin
				cnt = 4'd8;
			end
			send_word(rand64(), cnt, seeded && (w == 0), (w == 0) ? seed : rand64(),
				(w == nwords - 1) || ($urandom_range(49) == 0));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		calm = 1'b0;
		words_sent = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// the standard check string "123456789" from seed zero
		send_word(64'h3837363534333231, 4'd8, 1'b1, 64'd0, 1'b0);
		send_word(64'h0000000000000039, 4'd1, 1'b0, 64'd0, 1'b1);
		// data and seed extremes
		send_word(64'd0, 4'd8, 1'b1, 64'd0, 1'b1);
		send_word('1, 4'd8, 1'b1, 64'd0, 1'b1);
		send_word('1, 4'd8, 1'b1, '1, 1'b1);
		send_word(64'd0, 4'd8, 1'b1, '1, 1'b0);
		// zero byte count, with and without a seed load
		send_word(rand64(), 4'd0, 1'b1, rand64(), 1'b1);
		send_word(rand64(), 4'd0, 1'b0, rand64(), 1'b0);
		// every legal count in one message
		for (int c = 1; c <= 8; c++) begin
			send_word(rand64(), 4'(c), c == 1, 64'd0, c == 8);
		end
		// counts above eight saturate
		send_word(rand64(), 4'd9, 1'b1, 64'd0, 1'b0);
		send_word(rand64(), 4'd12, 1'b0, '1, 1'b0);
		send_word('1, 4'd15, 1'b0, 64'd0, 1'b1);
		// last without first: the remainder carries into the next word
		send_word(rand64(), 4'd8, 1'b0, rand64(), 1'b1);
		send_word(rand64(), 4'd5, 1'b0, rand64(), 1'b0);
		send_word(rand64(), 4'd3, 1'b0, rand64(), 1'b1);

		// random messages; a calm stretch, and one pause until the engine drains
		while (words_sent < WORD_TARGET) begin
			calm = (words_sent >= 450) && (words_sent < 650);
			if (words_sent >= 900 && words_sent < 920) begin
				s_tvalid <= 1'b0;
				while (pending != 0) @(negedge clk);
				@(negedge clk);
				words_sent = 920;
			end
			send_message();
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0) begin
			$display("crc64_nvme_eight_byte_engine_top: match");
		end else begin
			$display("crc64_nvme_eight_byte_engine_top: mismatch");
		end
		$finish;
	end

endmodule

// ----- crc64_nvme_eight_byte_engine_top.f -----
hw/rtl/crc64nv_pkg.sv
hw/rtl/crc64nv_fold.sv
hw/rtl/crc64_nvme_eight_byte_engine_top.sv
verif/crc64_nvme_eight_byte_engine_checker.sv
verif/crc64_nvme_eight_byte_engine_top_tb.sv
